// ----- rtl/frdm_pkg.sv -----
// Shared widths, reset values, codes and inter-module types of the frame ring descriptor manager.
package frdm_pkg;

   // Field and register widths.
   localparam int COUNT_W     = 64;
   localparam int RING_W      = 32;
   localparam int SLOTS_W     = 8;
   localparam int MAXLEN_W    = 24;
   localparam int PAYLOAD_W   = 24;
   localparam int EXT_W       = 16;
   localparam int TAG_W       = 32;
   localparam int LEN_W       = 25;
   localparam int ADDR_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int DIVISOR_W   = 32;

   // Defaults for the top-level parameters.
   localparam int SLOT_DEPTH_DEF    = 128;
   localparam int POSITION_BITS_DEF = 64;

   // Register reset values.
   localparam logic [RING_W-1:0]   RING_SIZE_RESET   = 32'd33792000;
   localparam logic [SLOTS_W-1:0]  FRAME_SLOTS_RESET = 8'd100;
   localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET     = 24'd307200;

   // A tenth of an 8-bit slot count is (count * 205) >> 11, exact for every such count.
   localparam logic [2*SLOTS_W-1:0] TENTH_MUL   = 16'd205;
   localparam int                   TENTH_SHIFT = 11;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TOO_LONG = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RING_SIZE   = 2'd0,
      CSR_FRAME_SLOTS = 2'd1,
      CSR_MAX_LEN     = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_PUT = 1'b0,
      KIND_GET = 1'b1
   } kind_type;

   // Request to and answer from the shared modulo unit.
   typedef struct packed {
      logic                 start;
      logic [COUNT_W-1:0]   dividend;
      logic [DIVISOR_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIVISOR_W-1:0] remainder;
   } mod_rsp_type;

endpackage

// ----- rtl/frdm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module frdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/frdm_mod_unit.sv -----
// Shared restoring modulo unit: one dividend bit per cycle, remainder held until the next start.
module frdm_mod_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  frdm_pkg::mod_req_type mod_req,
   output frdm_pkg::mod_rsp_type mod_rsp
);
   import frdm_pkg::*;

   localparam int CntBits = $clog2(COUNT_W + 1);

   logic [COUNT_W-1:0]   dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [CntBits-1:0]   cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[COUNT_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (mod_req.start) begin
         dvd_in = mod_req.dividend;
         dvs_in = mod_req.divisor;
         rem_in = '0;
         cnt_in = CntBits'(COUNT_W);
      end else if (cnt_ff != '0) begin
         dvd_in = dvd_ff << 1;
         // A borrow out of the trial subtraction means the divisor did not fit.
         rem_in = diff[DIVISOR_W] ? trial[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
         cnt_in = cnt_ff - CntBits'(1);
         if (cnt_ff == CntBits'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule

// ----- rtl/frame_ring_descriptor_manager_core.sv -----
// Top level of the frame ring descriptor manager: sequencer, ring state and configuration.
//
// This block keeps the bookkeeping for one ring of variable-length frames: a descriptor
// store of SLOT_DEPTH entries and running 64-bit write and read counts plus write and read
// byte positions (POSITION_BITS wide) into a data ring of data_ring_size bytes. A put
// transaction (kind 0) is rejected as too long when payload_len exceeds the maximum frame
// length; a frame that would reach the end of the ring skips to offset zero; the put is
// refused as ring full when slots minus a tenth of the slots are outstanding or the byte
// space lacks two maximum frames of margin. An accepted put stores the descriptor and
// returns the payload address, that is the frame start plus extend_len. A get transaction
// (kind 1) reports empty, or returns the oldest frame's start address, total length,
// extension length and tag, and advances the read position. Fields a result does not use
// are zero. One transaction is worked on at a time, and req_stall is high from acceptance
// until its result has been placed in the output register; the next transaction may be
// accepted while that result still waits on rsp_stall. Each position modulo ring size and
// each count modulo slot count goes through one shared modulo unit that retires one
// dividend bit per cycle. A put that stores a frame uses it twice; a get that returns a
// frame also uses it twice (plus one descriptor memory read); a full ring answer uses it
// once, and too long and empty answers do not use it. Configuration writes are always
// accepted (csr_ready is tied high) and must only be issued while no transaction is in
// progress.
module frame_ring_descriptor_manager_core #(
   parameter int SLOT_DEPTH    = frdm_pkg::SLOT_DEPTH_DEF,
   parameter int POSITION_BITS = frdm_pkg::POSITION_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_kind,
   input  logic [frdm_pkg::PAYLOAD_W-1:0]   req_payload_len,
   input  logic [frdm_pkg::EXT_W-1:0]       req_extend_len,
   input  logic [frdm_pkg::TAG_W-1:0]       req_head_tag,
   // Result channel.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [frdm_pkg::STATUS_W-1:0]    rsp_status,
   output logic [frdm_pkg::ADDR_W-1:0]      rsp_data_address,
   output logic [frdm_pkg::LEN_W-1:0]       rsp_frame_len,
   output logic [frdm_pkg::EXT_W-1:0]       rsp_frame_extend_len,
   output logic [frdm_pkg::TAG_W-1:0]       rsp_frame_tag,
   // Configuration write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [frdm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [frdm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import frdm_pkg::*;

   localparam int IdxBits  = $clog2(SLOT_DEPTH);
   localparam int TagLsb   = 0;
   localparam int ExtLsb   = TagLsb + TAG_W;
   localparam int LenLsb   = ExtLsb + EXT_W;
   localparam int OffLsb   = LenLsb + LEN_W;
   localparam int DescBits = OffLsb + POSITION_BITS;
   localparam int ProdBits = 2 * SLOTS_W;
   localparam int NeedBits = RING_W + 2;

   typedef enum logic [15:0] {
      S_IDLE      = 16'b0000_0000_0000_0001,
      S_PUT_LEN   = 16'b0000_0000_0000_0010,
      S_PUT_POS   = 16'b0000_0000_0000_0100,
      S_PUT_FIT   = 16'b0000_0000_0000_1000,
      S_PUT_NEED  = 16'b0000_0000_0001_0000,
      S_PUT_SPACE = 16'b0000_0000_0010_0000,
      S_PUT_SLOT  = 16'b0000_0000_0100_0000,
      S_PUT_STORE = 16'b0000_0000_1000_0000,
      S_PUT_ADV   = 16'b0000_0001_0000_0000,
      S_GET_CHECK = 16'b0000_0010_0000_0000,
      S_GET_SLOT  = 16'b0000_0100_0000_0000,
      S_GET_READ  = 16'b0000_1000_0000_0000,
      S_GET_POS   = 16'b0001_0000_0000_0000,
      S_GET_FIT   = 16'b0010_0000_0000_0000,
      S_GET_ADV   = 16'b0100_0000_0000_0000,
      S_RESULT    = 16'b1000_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [RING_W-1:0]   ring_size_ff, ring_size_in;
   logic [SLOTS_W-1:0]  frame_slots_ff, frame_slots_in;
   logic [MAXLEN_W-1:0] max_len_ff, max_len_in;

   // Ring state.
   logic [COUNT_W-1:0]       wr_count_ff, wr_count_in;
   logic [COUNT_W-1:0]       rd_count_ff, rd_count_in;
   logic [POSITION_BITS-1:0] wr_pos_ff, wr_pos_in;
   logic [POSITION_BITS-1:0] rd_pos_ff, rd_pos_in;

   // Working registers of the transaction in progress.
   kind_type                 kind_ff, kind_in;
   logic [PAYLOAD_W-1:0]     payload_ff, payload_in;
   logic [POSITION_BITS-1:0] cur_off_ff, cur_off_in;
   logic [LEN_W-1:0]         cur_len_ff, cur_len_in;
   logic [EXT_W-1:0]         cur_ext_ff, cur_ext_in;
   logic [TAG_W-1:0]         cur_tag_ff, cur_tag_in;
   logic [RING_W-1:0]        local_ff, local_in;
   logic [RING_W-1:0]        skip_ff, skip_in;
   logic [NeedBits-1:0]      need_ff, need_in;
   logic [POSITION_BITS-1:0] dist_ff, dist_in;
   logic                     occ_full_ff, occ_full_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   status_type               status_ff, status_in;

   // Output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]        rsp_addr_ff, rsp_addr_in;
   logic [LEN_W-1:0]         rsp_len_ff, rsp_len_in;
   logic [EXT_W-1:0]         rsp_ext_ff, rsp_ext_in;
   logic [TAG_W-1:0]         rsp_tag_ff, rsp_tag_in;

   // Derived values and unit connections.
   logic [RING_W-1:0]   size_eff;
   logic [SLOTS_W-1:0]  slots_eff;
   logic [ProdBits-1:0] tenth_prod;
   logic [SLOTS_W-1:0]  slots_thresh;
   logic [RING_W:0]     fit_sum;
   logic                fit_wrap;
   logic [RING_W-1:0]   room;
   logic                space_full;
   logic                out_free;
   logic                result_ok;
   logic                result_get;
   mod_req_type         mod_req;
   mod_rsp_type         mod_rsp;
   logic                ram_we;
   logic                ram_re;
   logic [IdxBits-1:0]  slot_idx;
   logic [DescBits-1:0] ram_wdata;
   logic [DescBits-1:0] ram_rdata;

   frdm_mod_unit u_mod_unit (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   frdm_ram #(
      .WIDTH (DescBits),
      .DEPTH (SLOT_DEPTH)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_idx),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (slot_idx),
      .rd_data (ram_rdata)
   );

   // A ring size of zero behaves as one; the slot count is kept in one to SLOT_DEPTH.
   always_comb begin
      size_eff  = (ring_size_ff == '0) ? RING_W'(1) : ring_size_ff;
      slots_eff = frame_slots_ff;
      if (slots_eff == '0) begin
         slots_eff = SLOTS_W'(1);
      end
      if (int'(slots_eff) > SLOT_DEPTH) begin
         slots_eff = SLOTS_W'(SLOT_DEPTH);
      end
      tenth_prod   = ProdBits'(slots_eff) * TENTH_MUL;
      slots_thresh = slots_eff - SLOTS_W'(tenth_prod >> TENTH_SHIFT);
   end

   // The frame fits in place unless its start plus total length reaches the ring end.
   always_comb begin
      fit_sum  = {1'b0, mod_rsp.remainder} + (RING_W + 1)'(cur_len_ff);
      fit_wrap = fit_sum >= {1'b0, size_eff};
   end

   // Space test. The room term only matters once the needed bytes are within the ring size,
   // and then it fits in the ring size width.
   always_comb begin
      room       = size_eff - need_ff[RING_W-1:0];
      space_full = occ_full_ff
                || (need_ff > NeedBits'(size_eff))
                || (dist_ff > POSITION_BITS'(room));
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign result_ok  = (status_ff == STATUS_OK);
   assign result_get = (kind_ff == KIND_GET);
   assign slot_idx   = mod_rsp.remainder[IdxBits-1:0];
   assign ram_wdata  = {wr_pos_ff + POSITION_BITS'(skip_ff), cur_len_ff, cur_ext_ff,
                        cur_tag_ff};

   always_comb begin
      state_in       = state_ff;
      ring_size_in   = ring_size_ff;
      frame_slots_in = frame_slots_ff;
      max_len_in     = max_len_ff;
      wr_count_in    = wr_count_ff;
      rd_count_in    = rd_count_ff;
      wr_pos_in      = wr_pos_ff;
      rd_pos_in      = rd_pos_ff;
      kind_in        = kind_ff;
      payload_in     = payload_ff;
      cur_off_in     = cur_off_ff;
      cur_len_in     = cur_len_ff;
      cur_ext_in     = cur_ext_ff;
      cur_tag_in     = cur_tag_ff;
      local_in       = local_ff;
      skip_in        = skip_ff;
      need_in        = need_ff;
      dist_in        = dist_ff;
      occ_full_in    = occ_full_ff;
      addr_in        = addr_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_ext_in     = rsp_ext_ff;
      rsp_tag_in     = rsp_tag_ff;
      mod_req.start    = 1'b0;
      mod_req.dividend = COUNT_W'(wr_pos_ff);
      mod_req.divisor  = size_eff;
      ram_we = 1'b0;
      ram_re = 1'b0;

      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_RING_SIZE: begin
               ring_size_in = csr_data[RING_W-1:0];
            end
            CSR_FRAME_SLOTS: begin
               frame_slots_in = csr_data[SLOTS_W-1:0];
            end
            CSR_MAX_LEN: begin
               max_len_in = csr_data[MAXLEN_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in    = kind_type'(req_kind);
               payload_in = req_payload_len;
               cur_len_in = LEN_W'(req_payload_len) + LEN_W'(req_extend_len);
               cur_ext_in = req_extend_len;
               cur_tag_in = req_head_tag;
               state_in   = (kind_type'(req_kind) == KIND_GET) ? S_GET_CHECK : S_PUT_LEN;
            end
         end
         S_PUT_LEN: begin
            if (payload_ff > max_len_ff) begin
               status_in = STATUS_TOO_LONG;
               state_in  = S_RESULT;
            end else begin
               mod_req.start = 1'b1;
               state_in      = S_PUT_POS;
            end
         end
         S_PUT_POS: begin
            if (mod_rsp.done) begin
               state_in = S_PUT_FIT;
            end
         end
         S_PUT_FIT: begin
            local_in = fit_wrap ? '0 : mod_rsp.remainder;
            skip_in  = fit_wrap ? (size_eff - mod_rsp.remainder) : '0;
            state_in = S_PUT_NEED;
         end
         S_PUT_NEED: begin
            need_in     = NeedBits'(skip_ff) + NeedBits'(cur_len_ff)
                        + NeedBits'({max_len_ff, 1'b0});
            dist_in     = wr_pos_ff - rd_pos_ff;
            occ_full_in = (wr_count_ff - rd_count_ff) >= COUNT_W'(slots_thresh);
            state_in    = S_PUT_SPACE;
         end
         S_PUT_SPACE: begin
            if (space_full) begin
               status_in = STATUS_FULL;
               state_in  = S_RESULT;
            end else begin
               mod_req.start    = 1'b1;
               mod_req.dividend = wr_count_ff;
               mod_req.divisor  = DIVISOR_W'(slots_eff);
               state_in         = S_PUT_SLOT;
            end
         end
         S_PUT_SLOT: begin
            if (mod_rsp.done) begin
               state_in = S_PUT_STORE;
            end
         end
         S_PUT_STORE: begin
            ram_we      = 1'b1;
            cur_off_in  = wr_pos_ff + POSITION_BITS'(skip_ff);
            addr_in     = local_ff + ADDR_W'(cur_ext_ff);
            wr_count_in = wr_count_ff + COUNT_W'(1);
            state_in    = S_PUT_ADV;
         end
         S_PUT_ADV: begin
            wr_pos_in = cur_off_ff + POSITION_BITS'(cur_len_ff);
            status_in = STATUS_OK;
            state_in  = S_RESULT;
         end
         S_GET_CHECK: begin
            if (rd_count_ff == wr_count_ff) begin
               status_in = STATUS_EMPTY;
               state_in  = S_RESULT;
            end else begin
               mod_req.start    = 1'b1;
               mod_req.dividend = rd_count_ff;
               mod_req.divisor  = DIVISOR_W'(slots_eff);
               state_in         = S_GET_SLOT;
            end
         end
         S_GET_SLOT: begin
            if (mod_rsp.done) begin
               ram_re   = 1'b1;
               state_in = S_GET_READ;
            end
         end
         S_GET_READ: begin
            cur_off_in       = ram_rdata[OffLsb +: POSITION_BITS];
            cur_len_in       = ram_rdata[LenLsb +: LEN_W];
            cur_ext_in       = ram_rdata[ExtLsb +: EXT_W];
            cur_tag_in       = ram_rdata[TagLsb +: TAG_W];
            mod_req.start    = 1'b1;
            mod_req.dividend = COUNT_W'(ram_rdata[OffLsb +: POSITION_BITS]);
            state_in         = S_GET_POS;
         end
         S_GET_POS: begin
            if (mod_rsp.done) begin
               state_in = S_GET_FIT;
            end
         end
         S_GET_FIT: begin
            local_in = fit_wrap ? '0 : mod_rsp.remainder;
            skip_in  = fit_wrap ? (size_eff - mod_rsp.remainder) : '0;
            state_in = S_GET_ADV;
         end
         S_GET_ADV: begin
            rd_pos_in   = cur_off_ff + POSITION_BITS'(skip_ff) + POSITION_BITS'(cur_len_ff);
            rd_count_in = rd_count_ff + COUNT_W'(1);
            addr_in     = local_ff;
            status_in   = STATUS_OK;
            state_in    = S_RESULT;
         end
         S_RESULT: begin
            // Wait for the output register to be free, then hand the result over.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = result_ok ? addr_ff : '0;
               rsp_len_in    = (result_ok && result_get) ? cur_len_ff : '0;
               rsp_ext_in    = (result_ok && result_get) ? cur_ext_ff : '0;
               rsp_tag_in    = (result_ok && result_get) ? cur_tag_ff : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         ring_size_ff   <= RING_SIZE_RESET;
         frame_slots_ff <= FRAME_SLOTS_RESET;
         max_len_ff     <= MAX_LEN_RESET;
         wr_count_ff    <= '0;
         rd_count_ff    <= '0;
         wr_pos_ff      <= '0;
         rd_pos_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ring_size_ff   <= ring_size_in;
         frame_slots_ff <= frame_slots_in;
         max_len_ff     <= max_len_in;
         wr_count_ff    <= wr_count_in;
         rd_count_ff    <= rd_count_in;
         wr_pos_ff      <= wr_pos_in;
         rd_pos_ff      <= rd_pos_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      payload_ff    <= payload_in;
      cur_off_ff    <= cur_off_in;
      cur_len_ff    <= cur_len_in;
      cur_ext_ff    <= cur_ext_in;
      cur_tag_ff    <= cur_tag_in;
      local_ff      <= local_in;
      skip_ff       <= skip_in;
      need_ff       <= need_in;
      dist_ff       <= dist_in;
      occ_full_ff   <= occ_full_in;
      addr_ff       <= addr_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_ext_ff    <= rsp_ext_in;
      rsp_tag_ff    <= rsp_tag_in;
   end

   assign req_stall            = (state_ff != S_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_data_address     = rsp_addr_ff;
   assign rsp_frame_len        = rsp_len_ff;
   assign rsp_frame_extend_len = rsp_ext_ff;
   assign rsp_frame_tag        = rsp_tag_ff;

endmodule

// ----- verif/frame_ring_descriptor_manager_core_tb.sv -----
// Self-checking testbench for the frame ring descriptor manager core.
module frame_ring_descriptor_manager_core_tb;
   import frdm_pkg::*;

   localparam int          SLOT_DEPTH    = SLOT_DEPTH_DEF;
   localparam int          SLOT_BITS     = $clog2(SLOT_DEPTH);
   localparam logic [63:0] POSITION_MASK = {64{1'b1}} >> (64 - POSITION_BITS_DEF);
   // Idle wait at the end of the run, meant to cover one transaction in flight.
   localparam int          DRAIN_CYCLES  = 300;
   localparam int          MAX_REPORTS   = 50;

   // One expected answer of the block, in the field order of the result channel.
   typedef struct packed {
      status_type          status;
      logic [ADDR_W-1:0]   address;
      logic [LEN_W-1:0]    length;
      logic [EXT_W-1:0]    extend;
      logic [TAG_W-1:0]    tag;
   } ring_answer_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_kind;
   logic [PAYLOAD_W-1:0]   req_payload_len;
   logic [EXT_W-1:0]       req_extend_len;
   logic [TAG_W-1:0]       req_head_tag;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [STATUS_W-1:0]    rsp_status;
   logic [ADDR_W-1:0]      rsp_data_address;
   logic [LEN_W-1:0]       rsp_frame_len;
   logic [EXT_W-1:0]       rsp_frame_extend_len;
   logic [TAG_W-1:0]       rsp_frame_tag;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   frame_ring_descriptor_manager_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_payload_len      (req_payload_len),
      .req_extend_len       (req_extend_len),
      .req_head_tag         (req_head_tag),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_data_address     (rsp_data_address),
      .rsp_frame_len        (rsp_frame_len),
      .rsp_frame_extend_len (rsp_frame_extend_len),
      .rsp_frame_tag        (rsp_frame_tag),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   // Shadow copy of the configuration registers, at their reset values.
   logic [RING_W-1:0]   shadow_ring_size = RING_SIZE_RESET;
   logic [SLOTS_W-1:0]  shadow_slots     = FRAME_SLOTS_RESET;
   logic [MAXLEN_W-1:0] shadow_max_len   = MAX_LEN_RESET;

   // Shadow ring bookkeeping: running counts, byte positions and the descriptor store.
   logic [63:0]        shadow_wr_count = '0;
   logic [63:0]        shadow_rd_count = '0;
   logic [63:0]        shadow_wr_pos   = '0;
   logic [63:0]        shadow_rd_pos   = '0;
   logic [63:0]        slot_start  [SLOT_DEPTH];
   logic [LEN_W-1:0]   slot_total  [SLOT_DEPTH];
   logic [EXT_W-1:0]   slot_extend [SLOT_DEPTH];
   logic [TAG_W-1:0]   slot_tag    [SLOT_DEPTH];

   // Answers owed by the block, oldest first.
   ring_answer_type answers_due[$];

   int mismatch_count    = 0;
   int req_idle_pct      = 0;
   int rsp_stall_pct     = 0;
   int rsp_hold_request  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a correct run ends far earlier than this.
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Works out the answer to one accepted transaction and advances the shadow ring.
   // A put that would run into the end of the data ring skips to offset zero; the skipped
   // bytes count against the free space just like the frame itself.
   function automatic ring_answer_type account_request(kind_type kind,
                                                       logic [PAYLOAD_W-1:0] payload,
                                                       logic [EXT_W-1:0] ext,
                                                       logic [TAG_W-1:0] tag);
      ring_answer_type        ans;
      logic [63:0]            size;
      logic [63:0]            slots;
      logic [63:0]            total;
      logic [63:0]            local_off;
      logic [63:0]            skip;
      logic [63:0]            need;
      logic [63:0]            gap;
      logic [SLOT_BITS-1:0]   idx;
      ans  = '0;
      skip = '0;
      size = (shadow_ring_size == 0) ? 64'd1 : 64'(shadow_ring_size);
      slots = (shadow_slots == 0) ? 64'd1 : 64'(shadow_slots);
      if (slots > 64'(SLOT_DEPTH)) slots = 64'(SLOT_DEPTH);
      if (kind == KIND_PUT) begin
         if (payload > shadow_max_len) begin
            ans.status = STATUS_TOO_LONG;
         end else begin
            total     = 64'(payload) + 64'(ext);
            local_off = shadow_wr_pos % size;
            if (local_off + total >= size) begin
               skip      = size - local_off;
               local_off = '0;
            end
            need = skip + total + 2 * 64'(shadow_max_len);
            gap  = (shadow_wr_pos - shadow_rd_pos) & POSITION_MASK;
            // Entry is refused at nine tenths of the slots or without two frames of margin.
            if ((shadow_wr_count - shadow_rd_count) >= (slots - slots / 10) ||
                need > size || gap > size - need) begin
               ans.status = STATUS_FULL;
            end else begin
               idx              = SLOT_BITS'((shadow_wr_count % slots) % SLOT_DEPTH);
               slot_start[idx]  = (shadow_wr_pos + skip) & POSITION_MASK;
               slot_total[idx]  = LEN_W'(total);
               slot_extend[idx] = ext;
               slot_tag[idx]    = tag;
               shadow_wr_pos    = (slot_start[idx] + total) & POSITION_MASK;
               shadow_wr_count  = shadow_wr_count + 1;
               ans.status       = STATUS_OK;
               ans.address      = ADDR_W'(local_off + 64'(ext));
            end
         end
      end else if (shadow_rd_count == shadow_wr_count) begin
         ans.status = STATUS_EMPTY;
      end else begin
         idx       = SLOT_BITS'((shadow_rd_count % slots) % SLOT_DEPTH);
         total     = 64'(slot_total[idx]);
         local_off = slot_start[idx] % size;
         if (local_off + total >= size) begin
            skip      = size - local_off;
            local_off = '0;
         end
         shadow_rd_pos   = (slot_start[idx] + skip + total) & POSITION_MASK;
         shadow_rd_count = shadow_rd_count + 1;
         ans.status      = STATUS_OK;
         ans.address     = ADDR_W'(local_off);
         ans.length      = slot_total[idx];
         ans.extend      = slot_extend[idx];
         ans.tag         = slot_tag[idx];
      end
      return ans;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", field, got, want, $realtime);
   endtask

   // Result checker: every accepted result transaction is compared with the oldest answer due.
   always @(posedge clock) begin
      ring_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            report_mismatch("result with nothing outstanding", 64'(rsp_status), 64'd0);
         end else begin
            want = answers_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_data_address !== want.address)
               report_mismatch("data_address", 64'(rsp_data_address), 64'(want.address));
            if (rsp_frame_len !== want.length)
               report_mismatch("frame_len", 64'(rsp_frame_len), 64'(want.length));
            if (rsp_frame_extend_len !== want.extend)
               report_mismatch("frame_extend_len", 64'(rsp_frame_extend_len),
                               64'(want.extend));
            if (rsp_frame_tag !== want.tag)
               report_mismatch("frame_tag", 64'(rsp_frame_tag), 64'(want.tag));
         end
      end
   end

   // Result side: random stall, or a long hold-off when one is requested.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // Offers one request transaction and waits until the block takes it. Called and left at a
   // falling edge; valid stays high into the next call unless an idle gap is drawn.
   task automatic send_request(kind_type kind, logic [PAYLOAD_W-1:0] payload,
                               logic [EXT_W-1:0] ext, logic [TAG_W-1:0] tag);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_payload_len <= payload;
      req_extend_len  <= ext;
      req_head_tag    <= tag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      answers_due.push_back(account_request(kind, payload, ext, tag));
      @(negedge clock);
   endtask

   // Stops offering requests and waits until every owed answer has come back.
   task automatic settle_requests();
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Fetches frames until the shadow ring is empty, so that slot indexing may change safely.
   task automatic drain_ring();
      while (shadow_rd_count != shadow_wr_count)
         send_request(KIND_GET, PAYLOAD_W'($urandom), EXT_W'($urandom), $urandom);
   endtask

   // Writes all three registers in consecutive cycles; the block must be idle.
   task automatic program_ring(logic [RING_W-1:0] size, logic [SLOTS_W-1:0] slots,
                               logic [MAXLEN_W-1:0] max_len);
      csr_index_type idx;
      for (int i = 0; i < 3; i++) begin
         idx = csr_index_type'(i);
         csr_valid <= 1'b1;
         csr_index <= idx;
         case (idx)
            CSR_RING_SIZE:   csr_data <= size;
            CSR_FRAME_SLOTS: csr_data <= CSR_DATA_W'(slots);
            default:         csr_data <= CSR_DATA_W'(max_len);
         endcase
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx)
            CSR_RING_SIZE:   shadow_ring_size = size;
            CSR_FRAME_SLOTS: shadow_slots = slots;
            default:         shadow_max_len = max_len;
         endcase
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic reconfigure(logic [RING_W-1:0] size, logic [SLOTS_W-1:0] slots,
                              logic [MAXLEN_W-1:0] max_len);
      drain_ring();
      settle_requests();
      program_ring(size, slots, max_len);
   endtask

   task automatic set_idling(int sender_pct, int receiver_pct);
      req_idle_pct  = sender_pct;
      rsp_stall_pct = receiver_pct;
   endtask

   // Mixed puts and gets. Most puts carry a legal length so that the ring fills, wraps and
   // empties; the rest are at the limit, above it, or fully random.
   task automatic run_mixed_traffic(int items);
      logic [PAYLOAD_W-1:0] payload;
      logic [EXT_W-1:0]     ext;
      int                   ext_cap;
      int                   pick;
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(99) < 45) begin
            send_request(KIND_GET, PAYLOAD_W'($urandom), EXT_W'($urandom), $urandom);
         end else begin
            pick = $urandom_range(9);
            if (pick <= 6)
               payload = PAYLOAD_W'($urandom_range(int'(shadow_max_len)));
            else if (pick == 7)
               payload = shadow_max_len;
            else if (pick == 8 && shadow_max_len != '1)
               payload = PAYLOAD_W'($urandom_range(24'hFFFFFF, int'(shadow_max_len) + 1));
            else
               payload = PAYLOAD_W'($urandom);
            ext_cap = (shadow_max_len < 24'hFFFF) ? int'(shadow_max_len) : 16'hFFFF;
            if ($urandom_range(9) < 8)
               ext = EXT_W'($urandom_range(ext_cap));
            else
               ext = EXT_W'($urandom);
            send_request(KIND_PUT, payload, ext, $urandom);
         end
      end
   endtask

   // At reset values: empty ring, longest legal frame, and lengths just and far above it.
   task automatic test_empty_and_length_limits();
      send_request(KIND_GET, '0, '0, '0);
      send_request(KIND_PUT, MAX_LEN_RESET, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(KIND_PUT, MAX_LEN_RESET + 24'd1, '0, 32'h1234_5678);
      send_request(KIND_PUT, 24'hFFFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(KIND_PUT, '0, '0, '0);
      send_request(KIND_GET, '0, '0, '0);
      send_request(KIND_GET, 24'hFFFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(KIND_GET, '0, '0, '0);
   endtask

   // Slot count corners (zero acts as one, above the depth saturates), a frame longer than the
   // ring, a zero ring size, and the largest ring and frame.
   task automatic test_slot_and_size_corners();
      reconfigure(32'd16, 8'd0, 24'd1);
      send_request(KIND_PUT, 24'd1, '0, 32'hA5A5_A5A5);
      send_request(KIND_PUT, 24'd1, '0, 32'h5A5A_5A5A);
      send_request(KIND_GET, '0, '0, '0);
      send_request(KIND_PUT, 24'd1, 16'd20, 32'h0F0F_0F0F);
      reconfigure(32'd0, 8'd1, 24'd1);
      send_request(KIND_PUT, '0, '0, '0);
      reconfigure(32'hFFFF_FFFF, 8'd255, 24'hFFFFFF);
      send_request(KIND_PUT, 24'hFFFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(KIND_GET, '0, '0, '0);
      reconfigure(32'hFFFF_FFFF, 8'd3, 24'hFFFFFF);
      for (int i = 0; i < 4; i++) send_request(KIND_PUT, 24'h800000, 16'h8000, $urandom);
   endtask

   // A frame that ends exactly at the ring end skips to offset zero.
   task automatic test_wrap_to_ring_start();
      reconfigure(32'd48, 8'd4, 24'd8);
      for (int i = 0; i < 3; i++) begin
         send_request(KIND_PUT, 24'd8, 16'd8, $urandom);
         send_request(KIND_GET, '0, '0, '0);
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming, so that the
   // output register fills and the block stalls its request side.
   task automatic test_receiver_hold_off();
      rsp_hold_request = 400;
      run_mixed_traffic(40);
   endtask

   task automatic test_mid_ring_traffic();
      reconfigure(32'd4096, 8'd20, 24'd300);
      run_mixed_traffic(460);
      test_receiver_hold_off();
   endtask

   task automatic test_tiny_ring_traffic();
      reconfigure(32'd16, 8'd255, 24'd1);
      run_mixed_traffic(350);
   endtask

   task automatic test_huge_ring_traffic();
      reconfigure(32'hFFFF_FFFF, 8'd128, 24'hFFFFFF);
      run_mixed_traffic(410);
      test_receiver_hold_off();
   endtask

   task automatic test_small_slot_traffic();
      reconfigure(32'd1000, 8'd12, 24'd64);
      run_mixed_traffic(400);
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = KIND_PUT;
      req_payload_len = '0;
      req_extend_len  = '0;
      req_head_tag    = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_RING_SIZE;
      csr_data        = '0;
      for (int i = 0; i < SLOT_DEPTH; i++) begin
         slot_start[i]  = '0;
         slot_total[i]  = '0;
         slot_extend[i] = '0;
         slot_tag[i]    = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(9, 58);
      test_empty_and_length_limits();
      test_slot_and_size_corners();
      test_wrap_to_ring_start();
      test_mid_ring_traffic();
      set_idling(58, 9);
      test_tiny_ring_traffic();
      set_idling(0, 0);
      test_huge_ring_traffic();
      test_small_slot_traffic();

      drain_ring();
      settle_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && answers_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
